/* design/accent_folding_mapper_macros.svh */
// ----------------------------------------------------------------------------
// accent_folding_mapper_macros
// assertion helpers shared by the accent folding mapper
// ----------------------------------------------------------------------------
`ifndef ACCENT_FOLDING_MAPPER_MACROS_SVH
`define ACCENT_FOLDING_MAPPER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define AFM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold outside reset
`define AFM_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

/* design/afm_pkg.sv */
// ----------------------------------------------------------------------------
// afm_pkg
// types, constants and fold tables of the accent folding mapper
// ----------------------------------------------------------------------------
package afm_pkg;

    localparam int CodeW = 21;

    localparam logic [CodeW-1:0] PassLimit = 21'h08A;
    localparam logic [CodeW-1:0] Latin1End = 21'h100;
    localparam logic [CodeW-1:0] ExtAEnd   = 21'h180;
    localparam logic [CodeW-1:0] Blk200Beg = 21'h200;
    localparam logic [CodeW-1:0] Blk200End = 21'h218;

    // input range classes
    typedef enum logic [2:0] {
        CLS_PASS   = 3'd0,
        CLS_LATIN1 = 3'd1,
        CLS_EXTA   = 3'd2,
        CLS_BLK200 = 3'd3,
        CLS_SUBST  = 3'd4
    } t_cls;

    typedef struct packed {
        logic             valid;
        t_cls             cls;
        logic [CodeW-1:0] code;
    } t_s1;

    typedef struct packed {
        logic             valid;
        logic [CodeW-1:0] code;
    } t_s2;

    // base letters of latin extended-a, first character is 0x100
    localparam logic [0:127][7:0] ExtABase =
        {"AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIiIiJjKkkLlLlLlLlLlNnNnNnnN",
         "nOoOoOoOoRrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs"};

    localparam logic [0:23][7:0] Blk200Map = {
        8'hc4, 8'he4, 8'hc2, 8'he2, 8'hcb, 8'heb, 8'hca, 8'hea,
        8'hcf, 8'hef, 8'hce, 8'hee, 8'hd6, 8'hf6, 8'hd4, 8'he4,
        "R",   "r",   "R",   "r",   8'hdc, 8'hfc, 8'hdb, 8'hfb
    };

    function automatic logic [7:0] fold_latin1(input logic [7:0] c);
        logic [7:0] up;
        logic [7:0] lc;
        logic [7:0] res;
        up = c & 8'hDF;
        lc = c & 8'h20;
        if (c == 8'h8a) begin
            res = "S";
        end else if (c == 8'h8e) begin
            res = "Z";
        end else if (c == 8'h9a) begin
            res = "s";
        end else if (c == 8'h9e) begin
            res = "z";
        end else if (c == 8'h9f) begin
            res = "Y";
        end else if (c == 8'hab || c == 8'hbb) begin
            res = "\"";
        end else if (c == 8'hff) begin
            res = "y";
        end else if (c[7:6] == 2'b00) begin
            res = c;
        end else if (up >= 8'hC0 && up <= 8'hC5) begin
            res = 8'("A") + lc;
        end else if (up == 8'hC7) begin
            res = 8'("C") + lc;
        end else if (up >= 8'hC8 && up <= 8'hCB) begin
            res = 8'("E") + lc;
        end else if (up >= 8'hCC && up <= 8'hCF) begin
            res = 8'("I") + lc;
        end else if (up == 8'hD0) begin
            res = 8'("D") + lc;
        end else if (up == 8'hD1) begin
            res = 8'("N") + lc;
        end else if ((up >= 8'hD2 && up <= 8'hD6) || up == 8'hD8) begin
            res = 8'("O") + lc;
        end else if (up >= 8'hD9 && up <= 8'hDC) begin
            res = 8'("U") + lc;
        end else if (up == 8'hDD) begin
            res = 8'("Y") + lc;
        end else if (up == 8'hDE) begin
            res = 8'("P") + lc;
        end else begin
            res = c;
        end
        return res;
    endfunction

    function automatic logic [CodeW-1:0] fold_ext_a(input logic [CodeW-1:0] c);
        logic [CodeW-1:0] res;
        unique case (c)
            21'h150: res = 21'h0d6;
            21'h151: res = 21'h0f6;
            21'h170: res = 21'h0dc;
            21'h171: res = 21'h0fc;
            default: res = {13'd0, ExtABase[c[6:0]]};
        endcase
        return res;
    endfunction

    // greek, cyrillic and romanian look-alikes
    function automatic logic [CodeW-1:0] substitute(input logic [CodeW-1:0] c);
        logic [CodeW-1:0] res;
        unique case (c)
            21'h17f: res = 21'(8'("s"));
            21'h218: res = 21'h15e;
            21'h219: res = 21'h15f;
            21'h21a: res = 21'h162;
            21'h21b: res = 21'h163;
            21'h391: res = 21'(8'("A"));
            21'h392: res = 21'(8'("B"));
            21'h393: res = 21'h413;
            21'h395: res = 21'(8'("E"));
            21'h396: res = 21'(8'("Z"));
            21'h397: res = 21'(8'("H"));
            21'h399: res = 21'(8'("I"));
            21'h39a: res = 21'(8'("K"));
            21'h39c: res = 21'(8'("M"));
            21'h39d: res = 21'(8'("N"));
            21'h39f: res = 21'(8'("O"));
            21'h3a0: res = 21'h41f;
            21'h3a1: res = 21'(8'("P"));
            21'h3a4: res = 21'(8'("T"));
            21'h3a5: res = 21'(8'("Y"));
            21'h3a6: res = 21'h424;
            21'h3a7: res = 21'(8'("X"));
            21'h3aa: res = 21'h0cf;
            21'h3ab: res = 21'h178;
            21'h3bf: res = 21'(8'("o"));
            21'h3c2: res = 21'h3c3;
            21'h3ca: res = 21'h0ef;
            21'h3cc: res = 21'h0f3;
            21'h400: res = 21'h0c8;
            21'h401: res = 21'h0cb;
            21'h405: res = 21'(8'("S"));
            21'h406: res = 21'(8'("I"));
            21'h407: res = 21'h0cf;
            21'h408: res = 21'(8'("J"));
            21'h450: res = 21'h0e8;
            21'h451: res = 21'h0eb;
            21'h455: res = 21'(8'("s"));
            21'h456: res = 21'(8'("i"));
            21'h457: res = 21'h0ef;
            21'h458: res = 21'(8'("j"));
            default: res = c;
        endcase
        return res;
    endfunction

endpackage

/* design/afm_decode.sv */
// ----------------------------------------------------------------------------
// afm_decode
// first stage: registers the code point and its range class
// ----------------------------------------------------------------------------
module afm_decode
    import afm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CodeW-1:0] i_code,
    output t_s1              o_s1
);

    logic             r_valid;
    t_cls             r_cls;
    logic [CodeW-1:0] r_code;
    t_cls             n_cls;

    always_comb begin
        priority if (i_code < PassLimit) begin
            n_cls = CLS_PASS;
        end else if (i_code < Latin1End) begin
            n_cls = CLS_LATIN1;
        end else if (i_code < ExtAEnd) begin
            n_cls = CLS_EXTA;
        end else if (i_code >= Blk200Beg && i_code < Blk200End) begin
            n_cls = CLS_BLK200;
        end else begin
            n_cls = CLS_SUBST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls  <= n_cls;
        r_code <= i_code;
    end

    assign o_s1 = '{valid: r_valid, cls: r_cls, code: r_code};

endmodule

/* design/afm_lookup.sv */
// ----------------------------------------------------------------------------
// afm_lookup
// second stage: table lookup per range class, registered result
// ----------------------------------------------------------------------------
module afm_lookup
    import afm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    logic             r_valid;
    logic [CodeW-1:0] r_code;
    logic [CodeW-1:0] n_code;

    always_comb begin
        unique case (i_s1.cls)
            CLS_PASS:   n_code = i_s1.code;
            CLS_LATIN1: n_code = {13'd0, fold_latin1(i_s1.code[7:0])};
            CLS_EXTA:   n_code = fold_ext_a(i_s1.code);
            CLS_BLK200: n_code = {13'd0, Blk200Map[i_s1.code[4:0]]};
            CLS_SUBST:  n_code = substitute(i_s1.code);
            default:    n_code = i_s1.code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_s2 = '{valid: r_valid, code: r_code};

endmodule

/* design/accent_folding_mapper.sv */
// a beat taken into the decode register moves on through the lookup register
//   to the output register, where it shows on o_folded_code with o_strobe
//   for the receiver to take
// throughput: one code point every cycle; busy is raised only while reset is
//   held, since every stage moves on each clock and the receiver cannot stall
// reset: synchronous, active low; clears the stage valid bits only
// ----------------------------------------------------------------------------
// accent_folding_mapper
// three stage pipeline folding accented code points to plain look-alikes
// ----------------------------------------------------------------------------
module accent_folding_mapper
    import afm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CodeW-1:0] i_code_point,
    output logic             o_strobe,
    output logic [CodeW-1:0] o_folded_code
);

`include "accent_folding_mapper_macros.svh"

    // stage handoff
    t_s1 w_s1;
    t_s2 w_s2;

    // output register, third stage
    logic             r_out_valid;
    logic [CodeW-1:0] r_out_code;

    // no back pressure anywhere, a beat can enter on every clock out of reset
    assign busy = !i_rst_n;

    // stage 1: range classification
    afm_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_code  (i_code_point),
        .o_s1    (w_s1)
    );

    // stage 2: latin-1 fold, extended-a table, 0x200 block table, substitutions
    afm_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .o_s2    (w_s2)
    );

    // stage 3: result strobe lasts exactly one cycle per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_code <= w_s2.code;
    end

    assign o_strobe      = r_out_valid;
    assign o_folded_code = r_out_code;

    // every result beat comes from a start beat passed through the decode, lookup and output registers
    `AFM_ASSERT_IMPL(a_strobe_origin, o_strobe, $past(start, 3), "result without input beat")

    // codes below the fold range come out untouched
    `AFM_ASSERT_IMPL(a_low_pass, o_strobe && ($past(i_code_point, 3) < PassLimit),
        o_folded_code == $past(i_code_point, 3), "low code altered")

    // the 0x200 block always folds into latin-1
    `AFM_ASSERT_IMPL(a_blk200_narrow,
        o_strobe && ($past(i_code_point, 3) >= Blk200Beg)
            && ($past(i_code_point, 3) < Blk200End),
        o_folded_code[CodeW-1:8] == '0, "0x200 block result out of latin-1")

endmodule
